### rtl/slcp_pkg.sv
`default_nettype none

package slcp_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_CMD    = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        K_DELAY   = 3'd0,
        K_DATA    = 3'd1,
        K_REG     = 3'd2,
        K_END     = 3'd3,
        K_BAD_OP  = 3'd4,
        K_BAD_VER = 3'd5
    } t_kind;

    localparam logic [7:0]  HEADER_BYTES  = 8'd64;
    localparam logic [7:0]  SKIP_END      = 8'd128;
    localparam logic [31:0] VER_PLAIN_MAX = 32'h0000_0150;
    localparam logic [31:0] VER_EXTENDED  = 32'h0000_0151;

    localparam logic [7:0] OP_DATA      = 8'h50;
    localparam logic [7:0] OP_SKIP_BYTE = 8'h4F;
    localparam logic [7:0] OP_REG_A     = 8'hA0;
    localparam logic [7:0] OP_REG_5E    = 8'h5E;
    localparam logic [7:0] OP_REG_5F    = 8'h5F;
    localparam logic [7:0] OP_WAIT      = 8'h61;
    localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
    localparam logic [7:0] OP_WAIT_PAL  = 8'h63;
    localparam logic [7:0] OP_END       = 8'h66;
    localparam logic [3:0] OP_SHORT_HI  = 4'h7;

    localparam logic [15:0] DELAY_NTSC = 16'd735;
    localparam logic [15:0] DELAY_PAL  = 16'd882;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  byte_position;
        logic [31:0] version_word;
        logic [7:0]  pending_opcode;
        logic [7:0]  first_operand;
        logic [1:0]  operands_left;
    } t_state;

    localparam t_state ST_RESET = '{
        phase:          PH_HEADER,
        byte_position:  8'd0,
        version_word:   32'd0,
        pending_opcode: 8'd0,
        first_operand:  8'd0,
        operands_left:  2'd0
    };

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [15:0] delay_samples;
        logic [7:0]  reg_number;
        logic [7:0]  data_byte;
    } t_result;

endpackage

`default_nettype wire

### rtl/slcp_decode.sv
`default_nettype none

module slcp_decode (
    input  slcp_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    output slcp_pkg::t_state  o_state,
    output slcp_pkg::t_result o_result
);
    import slcp_pkg::*;

    logic [7:0]  pos_inc;
    logic [31:0] ver_upd;
    logic        is_short_wait;

    assign pos_inc       = i_state.byte_position + 8'd1;
    assign is_short_wait = (i_byte[7:4] == OP_SHORT_HI);

    // version word lives in header bytes 8..11, little endian
    always_comb begin
        ver_upd = i_state.version_word;
        if (i_state.byte_position[7:2] == 6'd2) begin
            unique case (i_state.byte_position[1:0])
                2'd0: ver_upd[7:0]   = ver_upd[7:0]   | i_byte;
                2'd1: ver_upd[15:8]  = ver_upd[15:8]  | i_byte;
                2'd2: ver_upd[23:16] = ver_upd[23:16] | i_byte;
                default: ver_upd[31:24] = ver_upd[31:24] | i_byte;
            endcase
        end
    end

    // next state
    always_comb begin
        o_state = i_state;
        unique case (i_state.phase)
            PH_SKIP: begin
                o_state.byte_position = pos_inc;
                if (pos_inc >= SKIP_END) begin
                    o_state.phase         = PH_CMD;
                    o_state.operands_left = 2'd0;
                end
            end
            PH_CMD: begin
                priority if (i_state.operands_left >= 2'd2) begin
                    o_state.first_operand = i_byte;
                    o_state.operands_left = 2'd1;
                end else if (i_state.operands_left == 2'd1) begin
                    o_state.operands_left = 2'd0;
                end else begin
                    o_state.pending_opcode = i_byte;
                    if (!is_short_wait) begin
                        unique case (i_byte)
                            OP_WAIT, OP_REG_A, OP_REG_5E, OP_REG_5F:
                                o_state.operands_left = 2'd2;
                            OP_DATA, OP_SKIP_BYTE:
                                o_state.operands_left = 2'd1;
                            OP_WAIT_NTSC, OP_WAIT_PAL: ;
                            default: o_state = ST_RESET; // end or bad opcode
                        endcase
                    end
                end
            end
            default: begin
                o_state.version_word  = ver_upd;
                o_state.byte_position = pos_inc;
                if (pos_inc == HEADER_BYTES) begin
                    priority if (ver_upd <= VER_PLAIN_MAX) begin
                        o_state.phase         = PH_CMD;
                        o_state.operands_left = 2'd0;
                    end else if (ver_upd == VER_EXTENDED) begin
                        o_state.phase = PH_SKIP;
                    end else begin
                        o_state = ST_RESET;
                    end
                end
            end
        endcase
    end

    // result
    always_comb begin
        o_result = '{valid: 1'b0, kind: K_DELAY, delay_samples: 16'd0,
                     reg_number: 8'd0, data_byte: 8'd0};
        unique case (i_state.phase)
            PH_SKIP: ;
            PH_CMD: begin
                priority if (i_state.operands_left >= 2'd2) begin
                end else if (i_state.operands_left == 2'd1) begin
                    unique case (i_state.pending_opcode)
                        OP_WAIT: begin
                            o_result.valid         = 1'b1;
                            o_result.kind          = K_DELAY;
                            o_result.delay_samples = {i_byte, i_state.first_operand};
                        end
                        OP_DATA: begin
                            o_result.valid     = 1'b1;
                            o_result.kind      = K_DATA;
                            o_result.data_byte = i_byte;
                        end
                        OP_REG_A, OP_REG_5E, OP_REG_5F: begin
                            o_result.valid      = 1'b1;
                            o_result.kind       = K_REG;
                            o_result.reg_number = i_state.first_operand;
                            o_result.data_byte  = i_byte;
                        end
                        default: ;
                    endcase
                end else if (is_short_wait) begin
                    o_result.valid         = 1'b1;
                    o_result.kind          = K_DELAY;
                    o_result.delay_samples = {12'd0, i_byte[3:0]} + 16'd1;
                end else begin
                    unique case (i_byte)
                        OP_WAIT, OP_REG_A, OP_REG_5E, OP_REG_5F,
                        OP_DATA, OP_SKIP_BYTE: ;
                        OP_WAIT_NTSC: begin
                            o_result.valid         = 1'b1;
                            o_result.delay_samples = DELAY_NTSC;
                        end
                        OP_WAIT_PAL: begin
                            o_result.valid         = 1'b1;
                            o_result.delay_samples = DELAY_PAL;
                        end
                        OP_END: begin
                            o_result.valid = 1'b1;
                            o_result.kind  = K_END;
                        end
                        default: begin
                            o_result.valid = 1'b1;
                            o_result.kind  = K_BAD_OP;
                        end
                    endcase
                end
            end
            default: begin
                if (pos_inc == HEADER_BYTES && ver_upd > VER_PLAIN_MAX
                        && ver_upd != VER_EXTENDED) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = K_BAD_VER;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/sound_log_command_parser.sv
// Throughput: one byte per cycle while the sink takes results; the byte waits in the input
// register, passes one decode step, and its result (if any) goes to the result register.
// Decode state updates once per byte, so back-to-back bytes never stall unless the sink stalls.
// Reset (synchronous, active low): header phase, position and version cleared, both stages empty.
`default_nettype none

module sound_log_command_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [15:0] o_delay_samples,
    output logic [7:0]  o_reg_number,
    output logic [7:0]  o_data_byte
);
    import slcp_pkg::*;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parser state, advanced once per byte
    t_state  r_state;
    t_state  n_state;
    t_result dec_result;

    // result register
    logic        r_out_valid;
    t_kind       r_kind;
    logic [15:0] r_delay_samples;
    logic [7:0]  r_reg_number;
    logic [7:0]  r_data_byte;

    logic out_free;   // result register can take a new value this cycle
    logic proceed;    // byte in the input stage is decoded this cycle
    logic in_take;    // input transfer this cycle

    assign out_free = !r_out_valid || !i_stall;
    assign proceed  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    slcp_decode u_decode (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (dec_result)
    );

    // input stage: refills in the same cycle that the held byte is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || proceed) begin
            r_in_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_byte_value;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RESET;
        end else if (proceed) begin
            r_state <= n_state;
        end
    end

    // result register; bytes without a result just leave it empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proceed && dec_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && dec_result.valid) begin
            r_kind          <= dec_result.kind;
            r_delay_samples <= dec_result.delay_samples;
            r_reg_number    <= dec_result.reg_number;
            r_data_byte     <= dec_result.data_byte;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = 3'(r_kind);
    assign o_delay_samples = r_delay_samples;
    assign o_reg_number    = r_reg_number;
    assign o_data_byte     = r_data_byte;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

// Testbench for sound_log_command_parser.
// A behavioral copy of the parser runs on every byte that transfers into the block and queues
// the event that byte should produce. Each event that transfers out of the block is compared
// field by field against the oldest queued one.

module tb;
    import slcp_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int IDLE_PCT       = 7;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either side
    localparam int HOLD_CYCLES    = 200;    // long sink hold-off
    localparam int TAIL_CYCLES    = 10;     // padding after the last expected result
    localparam int MAX_PRINTED    = 40;

    // One parsed event as it leaves the block.
    typedef struct {
        t_kind       kind;
        logic [15:0] delay;
        logic [7:0]  reg_n;
        logic [7:0]  data;
    } t_event;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_byte_value;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_kind;
    logic [15:0] o_delay_samples;
    logic [7:0]  o_reg_number;
    logic [7:0]  o_data_byte;

    // Shadow parser state.
    t_phase      sh_phase;
    logic [7:0]  sh_pos;
    logic [31:0] sh_version;
    logic [7:0]  sh_opcode;
    logic [7:0]  sh_first;
    logic [1:0]  sh_left;

    t_event      events_due[$];
    t_event      head_event;

    int          errors        = 0;
    int          bytes_in      = 0;
    int          cmd_bytes     = 0;
    int          events_seen   = 0;
    int          kind_count[6] = '{default: 0};
    int          quiet_cycles  = 0;
    int          hold_request  = 0;
    bit          tx_steady     = 1'b0;
    bit          rx_steady     = 1'b0;

    sound_log_command_parser u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_byte_value    (i_byte_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_delay_samples (o_delay_samples),
        .o_reg_number    (o_reg_number),
        .o_data_byte     (o_data_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow parser
    // ------------------------------------------------------------------

    function automatic void restart_shadow();
        sh_phase   = PH_HEADER;
        sh_pos     = 8'd0;
        sh_version = 32'd0;
        sh_opcode  = 8'd0;
        sh_first   = 8'd0;
        sh_left    = 2'd0;
    endfunction

    function automatic void queue_event(t_kind k, logic [15:0] d, logic [7:0] r, logic [7:0] v);
        t_event ev;
        ev.kind  = k;
        ev.delay = d;
        ev.reg_n = r;
        ev.data  = v;
        events_due.push_back(ev);
    endfunction

    // Advance the shadow parser by one byte, queueing whatever event it yields.
    function automatic void log_parse_step(logic [7:0] b);
        case (sh_phase)
            PH_SKIP: begin
                // extended header: bytes 64..127 are dropped
                sh_pos = sh_pos + 8'd1;
                if (sh_pos >= SKIP_END) begin
                    sh_phase = PH_CMD;
                    sh_left  = 2'd0;
                end
            end
            PH_CMD: begin
                cmd_bytes++;
                if (sh_left >= 2'd2) begin
                    sh_first = b;
                    sh_left  = 2'd1;
                end else if (sh_left == 2'd1) begin
                    // last operand completes the pending opcode
                    sh_left = 2'd0;
                    case (sh_opcode)
                        OP_WAIT:  queue_event(K_DELAY, {b, sh_first}, 8'd0, 8'd0);
                        OP_DATA:  queue_event(K_DATA, 16'd0, 8'd0, b);
                        OP_REG_A, OP_REG_5E, OP_REG_5F:
                                  queue_event(K_REG, 16'd0, sh_first, b);
                        default: ;  // skip-byte opcode: consumed silently
                    endcase
                end else begin
                    sh_opcode = b;
                    if (b[7:4] == OP_SHORT_HI) begin
                        queue_event(K_DELAY, 16'(b[3:0]) + 16'd1, 8'd0, 8'd0);
                    end else begin
                        case (b)
                            OP_WAIT, OP_REG_A, OP_REG_5E, OP_REG_5F: sh_left = 2'd2;
                            OP_DATA, OP_SKIP_BYTE:                   sh_left = 2'd1;
                            OP_WAIT_NTSC: queue_event(K_DELAY, DELAY_NTSC, 8'd0, 8'd0);
                            OP_WAIT_PAL:  queue_event(K_DELAY, DELAY_PAL, 8'd0, 8'd0);
                            OP_END: begin
                                restart_shadow();
                                queue_event(K_END, 16'd0, 8'd0, 8'd0);
                            end
                            default: begin
                                restart_shadow();
                                queue_event(K_BAD_OP, 16'd0, 8'd0, 8'd0);
                            end
                        endcase
                    end
                end
            end
            default: begin
                // header (and any stray phase code): gather version from bytes 8..11
                if (sh_pos >= 8'd8 && sh_pos <= 8'd11)
                    sh_version = sh_version | (32'(b) << (8 * (sh_pos - 8'd8)));
                sh_pos = sh_pos + 8'd1;
                if (sh_pos >= HEADER_BYTES) begin
                    if (sh_version <= VER_PLAIN_MAX) begin
                        sh_phase = PH_CMD;
                        sh_left  = 2'd0;
                    end else if (sh_version == VER_EXTENDED) begin
                        sh_phase = PH_SKIP;
                    end else begin
                        restart_shadow();
                        queue_event(K_BAD_VER, 16'd0, 8'd0, 8'd0);
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Byte source: called at a falling edge, returns at a falling edge.
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b);
        // random bubbles ahead of the transfer
        while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_byte_value <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_in++;
        log_parse_step(b);
        @(negedge i_clk);
    endtask

    // Operand with extra weight on the all-zero and all-one values.
    function automatic logic [7:0] pick_operand();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return 8'h00;
        if (sel < 20) return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic send_header(input logic [31:0] version);
        for (int i = 0; i < 64; i++) begin
            if (i >= 8 && i <= 11) send_byte(version[8 * (i - 8) +: 8]);
            else                   send_byte(8'($urandom));
        end
        if (version == VER_EXTENDED)
            for (int i = 64; i < 128; i++) send_byte(8'($urandom));
    endtask

    function automatic logic [31:0] pick_version();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) return 32'($urandom_range(0, 'h150));
        if (sel < 65) return VER_PLAIN_MAX;
        if (sel < 82) return VER_EXTENDED;
        if (sel < 91) return 32'($urandom_range('h152, 'hFFFF));
        return $urandom | 32'h0001_0000;
    endfunction

    task automatic send_random_command();
        logic [7:0] op;
        int         sel;
        sel = $urandom_range(99);
        if (sel < 25) begin
            send_byte({OP_SHORT_HI, 4'($urandom)});
        end else if (sel < 99) begin
            case ($urandom_range(7))
                0:       op = OP_WAIT;
                1:       op = OP_WAIT_NTSC;
                2:       op = OP_WAIT_PAL;
                3:       op = OP_DATA;
                4:       op = OP_SKIP_BYTE;
                5:       op = OP_REG_A;
                6:       op = OP_REG_5E;
                default: op = OP_REG_5F;
            endcase
            send_byte(op);
            if (op == OP_DATA || op == OP_SKIP_BYTE) begin
                send_byte(pick_operand());
            end else if (op != OP_WAIT_NTSC && op != OP_WAIT_PAL) begin
                send_byte(pick_operand());
                send_byte(pick_operand());
            end
        end else begin
            // noise: any byte, usually an unknown opcode that aborts the file
            send_byte(8'($urandom));
        end
    endtask

    // One log file: header, then for a good version commands and an end-of-stream or bad opcode.
    task automatic send_random_file();
        logic [31:0] version;
        int          sel;
        // a broken earlier file may have left the parser mid-stream; flush it back
        // to the start of a header
        while (!(sh_phase == PH_HEADER && sh_pos == 8'd0)) begin
            if (sh_phase == PH_CMD) send_byte(OP_END);
            else                    send_byte(8'($urandom));
        end
        version = pick_version();
        send_header(version);
        if (version > VER_EXTENDED) return;
        repeat ($urandom_range(5, 60)) send_random_command();
        sel = $urandom_range(99);
        if (sel < 88)      send_byte(OP_END);
        else if (sel < 94) send_byte(8'($urandom_range(0, 'h4E)));
        else               send_byte(8'($urandom_range('hB0, 'hFF)));
    endtask

    // ------------------------------------------------------------------
    // Sink side: random stalls, plus a long hold-off on request.
    // ------------------------------------------------------------------

    initial begin : sink_stall
        int hold_left;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (rx_steady) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch @%0t: event %0d %s: got 0x%0h, want 0x%0h",
                     $realtime, events_seen, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            events_seen++;
            if (o_kind < 3'd6) kind_count[o_kind]++;
            if (events_due.size() == 0) begin
                report_mismatch("unexpected event, kind", 32'(o_kind), 32'hFFFF_FFFF);
            end else begin
                head_event = events_due.pop_front();
                if (o_kind !== head_event.kind)
                    report_mismatch("kind", 32'(o_kind), 32'(head_event.kind));
                if (o_delay_samples !== head_event.delay)
                    report_mismatch("delay_samples", 32'(o_delay_samples),
                                    32'(head_event.delay));
                if (o_reg_number !== head_event.reg_n)
                    report_mismatch("reg_number", 32'(o_reg_number), 32'(head_event.reg_n));
                if (o_data_byte !== head_event.data)
                    report_mismatch("data_byte", 32'(o_data_byte), 32'(head_event.data));
            end
        end
    end

    // Watchdog: any stretch without a transfer on either channel that runs past the
    // limit means the block is hung (the long hold-off is well inside it).
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d events still due",
                     quiet_cycles, events_due.size());
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every opcode at least once, with operand extremes and the zero-length delay.
    task automatic test_command_set();
        send_header(VER_PLAIN_MAX);
        send_byte(OP_WAIT);      send_byte(8'h00); send_byte(8'h00);
        send_byte(OP_WAIT);      send_byte(8'hFF); send_byte(8'hFF);
        send_byte(OP_WAIT_NTSC);
        send_byte(OP_WAIT_PAL);
        send_byte({OP_SHORT_HI, 4'h0});
        send_byte({OP_SHORT_HI, 4'hF});
        send_byte(OP_DATA);      send_byte(8'h00);
        send_byte(OP_DATA);      send_byte(8'hFF);
        send_byte(OP_REG_A);     send_byte(8'h00); send_byte(8'hFF);
        send_byte(OP_REG_5E);    send_byte(8'hFF); send_byte(8'h00);
        send_byte(OP_REG_5F);    send_byte(8'h5A); send_byte(8'hA5);
        send_byte(OP_SKIP_BYTE); send_byte(8'hFF);
        send_byte(OP_END);
    endtask

    // Extended header with skip region, bad versions, and unknown opcodes.
    task automatic test_version_paths();
        send_header(VER_EXTENDED);
        send_byte(OP_DATA); send_byte(8'h3C);
        send_byte(OP_END);
        send_header(32'h0000_0152);
        send_header(32'hFFFF_FFFF);
        send_header(32'h0000_0000);
        send_byte(8'h00);                       // unknown opcode
        send_header(32'h0000_0101);
        send_byte(OP_WAIT); send_byte(8'h34); send_byte(8'h12);
        send_byte(8'hFF);                       // unknown opcode after a completed command
    endtask

    // Sink holds off for a long stretch while short delays keep coming,
    // so the pipeline fills and the input channel has to stall.
    task automatic test_output_backpressure();
        send_header(32'h0000_0100);
        tx_steady    = 1'b1;
        hold_request = HOLD_CYCLES;
        repeat (80) send_byte({OP_SHORT_HI, 4'($urandom)});
        send_byte(OP_END);
        tx_steady    = 1'b0;
    endtask

    // Mostly well-formed files with random content until enough command bytes go by.
    task automatic test_random_files(input int cmd_target);
        int stop_at;
        stop_at = cmd_bytes + cmd_target;
        while (cmd_bytes < stop_at) send_random_file();
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_byte_value = 8'h00;
        restart_shadow();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_command_set();
        test_version_paths();
        test_output_backpressure();
        test_random_files(380);
        // long stretch with neither side idling
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        test_random_files(140);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain_results();

        $display("summary: %0d bytes in (%0d in command phase), %0d events checked",
                 bytes_in, cmd_bytes, events_seen);
        $display("summary: delay %0d, data %0d, reg %0d, end %0d, bad opcode %0d, bad version %0d",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3],
                 kind_count[4], kind_count[5]);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sound_log_command_parser.f
rtl/slcp_pkg.sv
rtl/slcp_decode.sv
rtl/sound_log_command_parser.sv
tb/sv/tb.sv
